[src/mcdrr_pkg.sv]
// ----------------------------------------------------------------------------
// mcdrr_pkg
// Shared types and constants of the multi-channel deficit round-robin core.
// ----------------------------------------------------------------------------
package mcdrr_pkg;

    localparam int NUM_QUEUES   = 16;
    localparam int QUEUE_DEPTH  = 64;
    localparam int DEFICIT_BITS = 24;

    localparam int QW = $clog2(NUM_QUEUES);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int OW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = QW + PW;

    localparam logic [DEFICIT_BITS-1:0] DEFICIT_MAX = '1;

    localparam logic [1:0] REG_QUANTUM = 2'd0;
    localparam logic [1:0] REG_LIMIT   = 2'd1;
    localparam logic [1:0] REG_TX      = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VISIT,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture command, write arrival
        logic first;     // start a search at last_served + 1
        logic visit;     // credit queue at pointer
        logic check;     // compare deficit with head length, grant if covered
        logic advance;   // step pointer
        logic finish;    // drive result
    } t_ctrl;

    // datapath -> controller
    typedef struct packed {
        logic run_search;  // accepted item needs a search
        logic nonempty;    // queue at pointer holds frames
        logic chan_free;   // its channel is free
        logic covered;     // deficit covers head frame
        logic wrap;        // pointer is at last queue of the pass
        logic eligible;    // pass saw an eligible queue
        logic quantum_nz;
    } t_stat;

endpackage

[src/mcdrr_ctrl.sv]
// ----------------------------------------------------------------------------
// mcdrr_ctrl
// Sequencer of the grant search: one queue visit per step.
// ----------------------------------------------------------------------------
module mcdrr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  mcdrr_pkg::t_stat i_stat,
    output mcdrr_pkg::t_ctrl o_ctrl,
    output logic             o_busy
);
    import mcdrr_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_start) n_state = ST_VISIT;
            ST_VISIT: begin
                if (!i_stat.run_search) n_state = ST_DONE;
                else                    n_state = ST_READ;
            end
            ST_READ: begin
                if (i_stat.nonempty && i_stat.chan_free) begin
                    n_state = ST_CHECK;
                end else if (i_stat.wrap &&
                             !(i_stat.eligible && i_stat.quantum_nz)) begin
                    n_state = ST_DONE;
                end
            end
            ST_CHECK: begin
                if (i_stat.covered) n_state = ST_DONE;
                else if (i_stat.wrap && !i_stat.quantum_nz) n_state = ST_DONE;
                else n_state = ST_READ;
            end
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        case (r_state)
            ST_IDLE:  o_ctrl.load  = i_start;
            ST_VISIT: o_ctrl.first = i_stat.run_search;
            ST_READ: begin
                o_ctrl.visit   = i_stat.nonempty;
                o_ctrl.advance = !(i_stat.nonempty && i_stat.chan_free);
            end
            ST_CHECK: begin
                o_ctrl.check   = 1'b1;
                o_ctrl.advance = !i_stat.covered;
            end
            ST_DONE:  o_ctrl.finish = 1'b1;
            default:  o_ctrl = '0;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

`ifndef SYNTHESIS
    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_ctrl.load, o_ctrl.first, o_ctrl.visit, o_ctrl.check,
                    o_ctrl.finish}) <= 1)
        else $error("controller issued two commands");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.finish |=> !o_busy)
        else $error("done not followed by idle");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("start not taken");
`endif

endmodule

[src/mcdrr_dp.sv]
// ----------------------------------------------------------------------------
// mcdrr_dp
// Queue state, length memory, deficits and the grant datapath.
// ----------------------------------------------------------------------------
module mcdrr_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mcdrr_pkg::t_ctrl           i_ctrl,
    input  logic                       i_cmd,
    input  logic [3:0]                 i_channel,
    input  logic [10:0]                i_frame_bytes,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [31:0]                i_cfg_data,
    output mcdrr_pkg::t_stat           o_stat,
    output logic                       o_valid,
    output logic                       o_dropped,
    output logic                       o_granted,
    output logic [3:0]                 o_grant_channel,
    output logic [10:0]                o_grant_bytes
);
    import mcdrr_pkg::*;

    logic [15:0]             r_quantum;
    logic [6:0]              r_limit;
    logic [4:0]              r_free_tx;
    logic [PW-1:0]           r_head [NUM_QUEUES];
    logic [OW-1:0]           r_occ  [NUM_QUEUES];
    logic [DEFICIT_BITS-1:0] r_def  [NUM_QUEUES];
    logic [NUM_QUEUES-1:0]   r_cfree;
    logic [QW-1:0]           r_last;
    logic [QW-1:0]           r_ptr;
    logic [QW-1:0]           r_stop;
    logic                    r_cmd;
    logic                    r_run;
    logic                    r_drop;
    logic                    r_elig;
    logic                    r_gnt;
    logic [QW-1:0]           r_gch;
    logic [10:0]             r_glen;
    logic [10:0]             r_rd;
    logic [10:0]             mem [NUM_QUEUES*QUEUE_DEPTH];

    logic [OW-1:0]           lim;
    logic                    ch_ok;
    logic [QW-1:0]           chq;
    logic [PW-1:0]           tail;
    logic                    arr_ok;
    logic                    end_ok;
    logic [DEFICIT_BITS:0]   dsum;
    logic [DEFICIT_BITS-1:0] dsat;

    assign chq   = i_channel[QW-1:0];
    assign ch_ok = (32'(i_channel) < NUM_QUEUES);
    always_comb begin
        if (r_limit == 7'd0 || 32'(r_limit) > QUEUE_DEPTH) lim = OW'(QUEUE_DEPTH);
        else lim = OW'(r_limit);
    end
    assign tail   = PW'(r_head[chq] + PW'(r_occ[chq]));
    assign arr_ok = !i_cmd && ch_ok && (r_occ[chq] < lim);
    assign end_ok = i_cmd && ch_ok && !r_cfree[chq];

    assign dsum = {1'b0, r_def[r_ptr]} + (DEFICIT_BITS+1)'(r_quantum);
    assign dsat = dsum[DEFICIT_BITS] ? DEFICIT_MAX : dsum[DEFICIT_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load && arr_ok) mem[{chq, tail}] <= i_frame_bytes;
        r_rd <= mem[{r_ptr, r_head[r_ptr]}];
    end

    assign o_stat.run_search = r_run;
    assign o_stat.nonempty   = (r_occ[r_ptr] != '0);
    assign o_stat.chan_free  = r_cfree[r_ptr];
    assign o_stat.covered    = (r_def[r_ptr] >= DEFICIT_BITS'(r_rd));
    assign o_stat.wrap       = (r_ptr == r_stop);
    assign o_stat.eligible   = r_elig || (r_cfree[r_ptr] && o_stat.nonempty);
    assign o_stat.quantum_nz = (r_quantum != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= 16'd1518;
            r_limit   <= '0;
            r_free_tx <= 5'd1;
            r_cfree   <= '1;
            r_last    <= '0;
            r_ptr     <= '0;
            r_stop    <= '0;
            r_run     <= 1'b0;
            r_elig    <= 1'b0;
            r_gnt     <= 1'b0;
            r_drop    <= 1'b0;
            r_cmd     <= 1'b0;
            o_valid   <= 1'b0;
            for (int q = 0; q < NUM_QUEUES; q++) begin
                r_head[q] <= '0;
                r_occ[q]  <= '0;
                r_def[q]  <= '0;
            end
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_QUANTUM: r_quantum <= i_cfg_data[15:0];
                    REG_LIMIT:   r_limit   <= i_cfg_data[6:0];
                    REG_TX:      r_free_tx <= i_cfg_data[4:0];
                    default:     ;
                endcase
            end
            if (i_ctrl.load) begin
                r_cmd  <= i_cmd;
                r_drop <= !i_cmd && !arr_ok;
                r_gnt  <= 1'b0;
                r_run  <= arr_ok ? (r_free_tx != '0) : end_ok;
                if (arr_ok) r_occ[chq] <= r_occ[chq] + OW'(1);
                if (end_ok) r_cfree[chq] <= 1'b1;
            end
            if (i_ctrl.first) begin
                r_ptr  <= QW'(r_last + QW'(1));
                r_stop <= r_last;
                r_elig <= 1'b0;
            end
            if (i_ctrl.visit) r_def[r_ptr] <= dsat;
            if (i_ctrl.advance) begin
                r_ptr <= QW'(r_ptr + QW'(1));
                if (r_ptr == r_stop) r_elig <= 1'b0;
                else r_elig <= o_stat.eligible;
            end
            if (i_ctrl.check && o_stat.covered) begin
                r_gnt  <= 1'b1;
                r_gch  <= r_ptr;
                r_glen <= r_rd;
                r_last <= r_ptr;
                r_head[r_ptr]  <= PW'(r_head[r_ptr] + PW'(1));
                r_occ[r_ptr]   <= r_occ[r_ptr] - OW'(1);
                r_cfree[r_ptr] <= 1'b0;
                if (r_occ[r_ptr] == OW'(1)) r_def[r_ptr] <= '0;
                else r_def[r_ptr] <= r_def[r_ptr] - DEFICIT_BITS'(r_rd);
            end
            if (i_ctrl.finish) begin
                o_valid <= 1'b1;
                if (r_cmd && r_run && !r_gnt && r_free_tx != 5'd31)
                    r_free_tx <= r_free_tx + 5'd1;
                if (!r_cmd && r_gnt) r_free_tx <= r_free_tx - 5'd1;
            end
        end
    end

    assign o_dropped       = r_drop;
    assign o_granted       = r_gnt;
    assign o_grant_channel = r_gnt ? 4'(r_gch) : 4'd0;
    assign o_grant_bytes   = r_gnt ? r_glen : 11'd0;

`ifndef SYNTHESIS
    a_drop_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_dropped && o_granted))
        else $error("drop and grant together");
    a_grant_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.check && o_stat.covered) |=> !r_cfree[$past(r_ptr)])
        else $error("granted channel still free");
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_occ[r_ptr]) <= QUEUE_DEPTH)
        else $error("occupancy overflow");
`endif

endmodule

[src/multi_channel_deficit_round_robin_core.sv]
// ----------------------------------------------------------------------------
// multi_channel_deficit_round_robin_core
// Idle loads an item; visit goes to done for a drop or no search, else read
// visits each queue, plus check for a queue with frames on a free channel.
// A search visits up to 16 queues per round, rounds going on until a deficit
// covers a frame, a round sees no eligible queue or the quantum is zero. One
// item is in flight at a time (busy high meanwhile); the next word is taken
// in the result cycle. The result strobe lasts one cycle; the receiver cannot
// stall. Reset (synchronous, active low) empties queues, frees all channels.
// ----------------------------------------------------------------------------
module multi_channel_deficit_round_robin_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cmd,
    input  logic [3:0]  i_channel,
    input  logic [10:0] i_frame_bytes,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    output logic        o_dropped,
    output logic        o_granted,
    output logic [3:0]  o_grant_channel,
    output logic [10:0] o_grant_bytes
);
    import mcdrr_pkg::*;

    t_ctrl ctrl;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    mcdrr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .o_busy  (busy)
    );

    mcdrr_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (ctrl),
        .i_cmd           (i_cmd),
        .i_channel       (i_channel),
        .i_frame_bytes   (i_frame_bytes),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_idx       (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_stat          (stat),
        .o_valid         (o_valid),
        .o_dropped       (o_dropped),
        .o_granted       (o_granted),
        .o_grant_channel (o_grant_channel),
        .o_grant_bytes   (o_grant_bytes)
    );

endmodule

[tb/multi_channel_deficit_round_robin_core_tb.sv]
// ----------------------------------------------------------------------------
// multi_channel_deficit_round_robin_core_tb
// Self-checking bench for the deficit round-robin core. Traffic is built phase
// by phase. A scheduler model in the bench predicts the drop/grant outcome of
// each word when the word is queued. The monitor checks every result strobe
// in order against those predictions. Registers are rewritten between phases
// while the core is idle.
// ----------------------------------------------------------------------------
module multi_channel_deficit_round_robin_core_tb;
    import mcdrr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CMD_ARRIVAL = 1'b0;
    localparam logic CMD_END     = 1'b1;

    typedef struct {
        logic        cmd;
        logic [3:0]  channel;
        logic [10:0] bytes;
    } t_word;

    typedef struct {
        logic        dropped;
        logic        granted;
        logic [3:0]  gch;
        logic [10:0] glen;
    } t_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cmd;
    logic [3:0]  i_channel;
    logic [10:0] i_frame_bytes;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        o_valid;
    logic        o_dropped;
    logic        o_granted;
    logic [3:0]  o_grant_channel;
    logic [10:0] o_grant_bytes;

    multi_channel_deficit_round_robin_core dut (.*);

    // scheduler model
    logic [10:0]             frame_len [NUM_QUEUES][QUEUE_DEPTH];
    logic [5:0]              q_head    [NUM_QUEUES];
    int unsigned             q_count   [NUM_QUEUES];
    logic [DEFICIT_BITS-1:0] q_credit  [NUM_QUEUES];
    bit                      ch_idle   [NUM_QUEUES];
    int unsigned             tx_pool;
    logic [3:0]              rr_last;
    logic [15:0]             cfg_quantum;
    logic [6:0]              cfg_limit;

    t_word    pending_words[$];
    t_outcome outcome_expect[$];
    int       errors;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic pick_grant(output bit g, output logic [3:0] gch, output logic [10:0] glen);
        logic [3:0]  first;
        logic [3:0]  q;
        bit          elig;
        logic [24:0] sum;
        logic [10:0] len;
        g = 0; gch = '0; glen = '0;
        first = rr_last + 4'd1;
        do begin
            elig = 0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                q = first + 4'(i);
                if (q_count[q] == 0) continue;
                sum = {1'b0, q_credit[q]} + cfg_quantum;
                q_credit[q] = sum > DEFICIT_MAX ? DEFICIT_MAX : sum[DEFICIT_BITS-1:0];
                if (!ch_idle[q]) continue;
                elig = 1;
                len = frame_len[q][q_head[q]];
                if (q_credit[q] >= len) begin
                    q_credit[q] -= len;
                    q_head[q] = q_head[q] + 6'd1;
                    q_count[q]--;
                    if (q_count[q] == 0) q_credit[q] = '0;
                    ch_idle[q] = 0;
                    rr_last = q;
                    g = 1; gch = q; glen = len;
                    return;
                end
            end
        end while (elig && cfg_quantum != 0);
    endtask

    task automatic send(input logic cmd, input logic [3:0] ch, input logic [10:0] bytes);
        t_outcome o;
        int unsigned lim;
        bit g;
        o = '{1'b0, 1'b0, 4'd0, 11'd0};
        pending_words.push_back('{cmd, ch, bytes});
        if (cmd == CMD_ARRIVAL) begin
            lim = (cfg_limit == 0 || cfg_limit > QUEUE_DEPTH) ? QUEUE_DEPTH : cfg_limit;
            if (q_count[ch] >= lim) begin
                o.dropped = 1;
            end else begin
                frame_len[ch][6'(q_head[ch] + q_count[ch])] = bytes;
                q_count[ch]++;
                if (tx_pool > 0) begin
                    pick_grant(g, o.gch, o.glen);
                    o.granted = g;
                    if (g) tx_pool--;
                end
            end
        end else if (!ch_idle[ch]) begin
            ch_idle[ch] = 1;
            pick_grant(g, o.gch, o.glen);
            o.granted = g;
            if (!g && tx_pool < 31) tx_pool++;
        end
        outcome_expect.push_back(o);
    endtask

    task automatic settle();
        while (pending_words.size() > 0 || outcome_expect.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_QUANTUM: cfg_quantum = val[15:0];
            REG_LIMIT:   cfg_limit = val[6:0];
            REG_TX:      tx_pool = val[4:0];
            default: ;
        endcase
    endtask

    function automatic int busy_channel();
        int c[$];
        for (int q = 0; q < NUM_QUEUES; q++) if (!ch_idle[q]) c.push_back(q);
        return c.size() == 0 ? -1 : c[$urandom_range(0, c.size() - 1)];
    endfunction

    task automatic random_traffic(input int n, input int unsigned fmax);
        int b;
        repeat (n) begin
            b = busy_channel();
            if ($urandom_range(0, 99) < 55)
                send(CMD_ARRIVAL, 4'($urandom_range(0, 15)), 11'($urandom_range(0, fmax)));
            else if (b >= 0 && $urandom_range(0, 99) < 85)
                send(CMD_END, 4'(b), 11'($urandom));
            else
                send(CMD_END, 4'($urandom_range(0, 15)), 11'($urandom));
        end
    endtask

    // with no busy channel left, an arrival restarts the search
    task automatic drain();
        int b;
        int nq;
        forever begin
            nq = -1;
            for (int q = NUM_QUEUES - 1; q >= 0; q--) if (q_count[q] != 0) nq = q;
            b = busy_channel();
            if (nq < 0 && b < 0) break;
            if (b >= 0) send(CMD_END, 4'(b), 11'($urandom));
            else        send(CMD_ARRIVAL, 4'(nq), 11'($urandom));
        end
    endtask

    task automatic phase(input logic [15:0] qv, input logic [6:0] lv, input logic [4:0] tv,
                         input int n, input int unsigned fmax);
        settle();
        write_reg(REG_QUANTUM, {16'($urandom), qv});
        write_reg(REG_LIMIT, {25'($urandom), lv});
        write_reg(REG_TX, {27'($urandom), tv});
        random_traffic(n, fmax);
    endtask

    // driver
    int  burst_left;
    int  gap_left;
    logic fire;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (start && !busy) void'(pending_words.pop_front());
            fire = 1'b0;
            if (start && busy) begin
                fire = 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (pending_words.size() > 0) begin
                fire = 1'b1;
                i_cmd         <= pending_words[0].cmd;
                i_channel     <= pending_words[0].channel;
                i_frame_bytes <= pending_words[0].bytes;
                if (burst_left == 0) burst_left = $urandom_range(1, 24);
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
            start <= fire;
        end
    end

    // monitor
    t_outcome want;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (outcome_expect.size() == 0) begin
                $display("%0t: unexpected result word", $time);
                errors++;
            end else begin
                want = outcome_expect.pop_front();
                if (o_dropped !== want.dropped) begin
                    $display("%0t: dropped exp %0d got %0d", $time, want.dropped, o_dropped);
                    errors++;
                end
                if (o_granted !== want.granted) begin
                    $display("%0t: granted exp %0d got %0d", $time, want.granted, o_granted);
                    errors++;
                end
                if (o_grant_channel !== want.gch) begin
                    $display("%0t: grant_channel exp %0d got %0d", $time, want.gch,
                             o_grant_channel);
                    errors++;
                end
                if (o_grant_bytes !== want.glen) begin
                    $display("%0t: grant_bytes exp %0d got %0d", $time, want.glen,
                             o_grant_bytes);
                    errors++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("multi_channel_deficit_round_robin_core test failed");
        $finish;
    end

    initial begin
        errors = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = 1'b0;
        i_channel = '0;
        i_frame_bytes = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        for (int q = 0; q < NUM_QUEUES; q++) begin
            q_head[q] = '0;
            q_count[q] = 0;
            q_credit[q] = '0;
            ch_idle[q] = 1;
        end
        cfg_quantum = 16'd1518;
        cfg_limit = '0;
        tx_pool = 1;
        rr_last = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        send(CMD_END, 4'd3, 11'h7FF);
        send(CMD_ARRIVAL, 4'd15, 11'd2047);
        send(CMD_ARRIVAL, 4'd0, 11'd0);
        send(CMD_ARRIVAL, 4'd0, 11'd1024);
        send(CMD_ARRIVAL, 4'd1, 11'd1);
        send(CMD_END, 4'd15, 11'd0);
        send(CMD_END, 4'd0, 11'h7FF);
        send(CMD_ARRIVAL, 4'd8, 11'h555);
        send(CMD_ARRIVAL, 4'd7, 11'h2AA);
        send(CMD_END, 4'd1, 11'd0);
        send(CMD_END, 4'd15, 11'd0);
        send(CMD_END, 4'd0, 11'd0);
        send(CMD_END, 4'd8, 11'd0);
        send(CMD_END, 4'd7, 11'd0);
        send(CMD_END, 4'd7, 11'd0);
        random_traffic(380, 2047);

        phase(16'd65535, 7'd1, 5'd16, 300, 2047);
        phase(16'd700, 7'd64, 5'd16, 250, 2047);
        phase(16'd0, 7'd2, 5'd4, 120, 2047);
        phase(16'd65535, 7'd0, 5'd3, 300, 2047);
        phase(16'd2000, 7'd127, 5'd31, 200, 2047);
        phase(16'd1518, 7'd5, 5'd0, 100, 2047);
        phase(16'd65535, 7'd0, 5'd16, 0, 0);
        drain();
        phase(16'd1, 7'd3, 5'd2, 120, 15);
        phase(16'd1200, 7'd64, 5'd1, 180, 2047);

        settle();
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("multi_channel_deficit_round_robin_core test passed");
        else
            $display("multi_channel_deficit_round_robin_core test failed");
        $finish;
    end

endmodule

[multi_channel_deficit_round_robin_core.f]
src/mcdrr_pkg.sv
src/mcdrr_ctrl.sv
src/mcdrr_dp.sv
src/multi_channel_deficit_round_robin_core.sv
tb/multi_channel_deficit_round_robin_core_tb.sv
